/* rtl/task_lifecycle_flow_control_macros.svh */
// Assertion macros used by the task lifecycle controller top level.
`ifndef TASK_LIFECYCLE_FLOW_CONTROL_MACROS_SVH
`define TASK_LIFECYCLE_FLOW_CONTROL_MACROS_SVH

// Check an implication on every rising edge, skipped while reset is held.
`define TLFC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent, skipped while reset is held.
`define TLFC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tlfc_pkg.sv */
// Types and codes shared by the task lifecycle controller modules.
package tlfc_pkg;

  // Command codes carried by a request
  typedef enum logic [3:0] {
    CMD_RESET    = 4'd0,
    CMD_START    = 4'd1,
    CMD_PAUSE    = 4'd2,
    CMD_RESUME   = 4'd3,
    CMD_FLUSH    = 4'd4,
    CMD_KILL     = 4'd5,
    CMD_FAULT    = 4'd6,
    CMD_DISRUPT  = 4'd7,
    CMD_PREPARE  = 4'd8,
    CMD_ENQUEUE  = 4'd9,
    CMD_DEQUEUE  = 4'd10,
    CMD_COMPLETE = 4'd11
  } cmd_t;

  // Emitted action codes
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_PREPARE  = 3'd1,
    ACT_RUN      = 3'd2,
    ACT_STOP     = 3'd3,
    ACT_CANCEL   = 3'd4,
    ACT_FLUSH    = 3'd5,
    ACT_FINALIZE = 3'd6
  } action_t;

  localparam logic [31:0] HIGH_WATER_RESET = 32'd52428800;  // 50 MiB

  // Result of one command, as computed by the core
  typedef struct packed {
    logic       accepted;
    action_t    first_action;
    action_t    second_action;
    logic [2:0] task_state;
    logic       runnable;
    logic       busy_res;
    logic       healthy;
    logic       overflowed;
  } result_t;

endpackage

/* rtl/tlfc_core.sv */
// Lifecycle state, buffer counters and per-command next-state logic.
module tlfc_core
  import tlfc_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        fire,
  input  logic [3:0]  cmd,
  input  logic [31:0] buffer_total,
  input  logic [31:0] byte_amount,
  input  logic [2:0]  done_action,
  output result_t     result
);

  localparam int WB = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  typedef enum logic [2:0] {
    PH_QUEUED   = 3'd0,
    PH_WAITING  = 3'd1,
    PH_ACTIVE   = 3'd2,
    PH_PAUSED   = 3'd3,
    PH_COMPLETE = 3'd4,
    PH_KILLED   = 3'd5
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] queued_r, queued_nxt;
  logic [COUNT_BITS-1:0] enq_r, enq_nxt;
  logic [COUNT_BITS-1:0] deq_r, deq_nxt;
  logic [COUNT_BITS-1:0] exp_r, exp_nxt;
  logic                  err_r, err_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [31:0]           high_water_r;

  logic                  runnable_cur, busy_cur;
  logic [WB:0]           add_sum;
  logic [COUNT_BITS-1:0] q_add;
  logic [WB-1:0]         q_ext, b_ext, q_diff;
  logic [COUNT_BITS-1:0] q_sub;
  logic [COUNT_BITS-1:0] enq_inc, deq_inc;
  logic                  ok;
  action_t               act0, act1;

  // Truncate or extend the buffer total to the counter width
  function automatic logic [COUNT_BITS-1:0] q_prep(input logic [31:0] total);
    logic [WB-1:0] ext;
    ext = WB'(total);
    return ext[COUNT_BITS-1:0];
  endfunction

  assign runnable_cur = (phase_r == PH_ACTIVE) || (phase_r == PH_WAITING) ||
                        (phase_r == PH_PAUSED);
  assign busy_cur     = (phase_r == PH_ACTIVE) || (phase_r == PH_WAITING);

  // Saturating add and subtract of the buffered byte count
  assign q_ext   = WB'(queued_r);
  assign b_ext   = WB'(byte_amount);
  assign add_sum = {1'b0, q_ext} + {1'b0, b_ext};
  assign q_add   = (add_sum > (WB+1)'({COUNT_BITS{1'b1}})) ? {COUNT_BITS{1'b1}}
                                                           : add_sum[COUNT_BITS-1:0];
  assign q_diff  = q_ext - b_ext;
  assign q_sub   = (b_ext > q_ext) ? '0 : q_diff[COUNT_BITS-1:0];
  assign enq_inc = enq_r + COUNT_BITS'(1);
  assign deq_inc = deq_r + COUNT_BITS'(1);

  // Decode the command against the current phase
  always_comb begin
    phase_nxt  = phase_r;
    queued_nxt = queued_r;
    enq_nxt    = enq_r;
    deq_nxt    = deq_r;
    exp_nxt    = exp_r;
    err_nxt    = err_r;
    ovf_nxt    = ovf_r;
    ok         = 1'b0;
    act0       = ACT_NONE;
    act1       = ACT_NONE;
    case (cmd)
      CMD_RESET: begin
        phase_nxt  = PH_QUEUED;
        queued_nxt = '0;
        enq_nxt    = '0;
        deq_nxt    = '0;
        exp_nxt    = '0;
        err_nxt    = 1'b0;
        ovf_nxt    = 1'b0;
        ok         = 1'b1;
      end
      CMD_START: begin
        if (phase_r == PH_QUEUED) begin
          act0      = ACT_PREPARE;
          act1      = ACT_RUN;
          phase_nxt = PH_WAITING;
          ok        = 1'b1;
        end
      end
      CMD_PAUSE: begin
        if (phase_r == PH_QUEUED || busy_cur) begin
          if (phase_r == PH_ACTIVE) act0 = ACT_STOP;
          phase_nxt = PH_PAUSED;
          ok        = 1'b1;
        end
      end
      CMD_RESUME: begin
        if (phase_r == PH_PAUSED) begin
          if (exp_r != '0) begin
            act0      = ACT_RUN;
            phase_nxt = PH_WAITING;
          end else begin
            phase_nxt = PH_QUEUED;
          end
          ok = 1'b1;
        end
      end
      CMD_FLUSH: begin
        if (runnable_cur) begin
          act0 = ACT_FLUSH;
          ok   = 1'b1;
        end
      end
      CMD_KILL: begin
        if (phase_r != PH_KILLED) begin
          if (busy_cur) begin
            act0 = ACT_STOP;
            act1 = ACT_CANCEL;
          end else if (phase_r == PH_PAUSED) begin
            act0 = ACT_CANCEL;
          end
          phase_nxt = PH_KILLED;
          ok        = 1'b1;
        end
      end
      CMD_FAULT: begin
        if (runnable_cur) begin
          if (busy_cur) begin
            act0 = ACT_STOP;
            act1 = ACT_CANCEL;
          end else begin
            act0 = ACT_CANCEL;
          end
          phase_nxt = PH_COMPLETE;
          err_nxt   = 1'b1;
          ok        = 1'b1;
        end
      end
      CMD_DISRUPT: begin
        if (phase_r == PH_ACTIVE) begin
          phase_nxt = PH_WAITING;
          ok        = 1'b1;
        end
      end
      CMD_PREPARE: begin
        if (phase_r == PH_WAITING && exp_r == '0) begin
          exp_nxt = q_prep(buffer_total);
          ok      = 1'b1;
        end
      end
      CMD_ENQUEUE: begin
        if (runnable_cur) begin
          queued_nxt = q_add;
          enq_nxt    = enq_inc;
          if (phase_r == PH_ACTIVE) begin
            if (enq_inc == exp_r) begin
              act0 = ACT_STOP;
            end else if (WB'(q_add) >= WB'(high_water_r)) begin
              act0      = ACT_STOP;
              phase_nxt = PH_WAITING;
              ovf_nxt   = 1'b1;
            end
          end else if (phase_r == PH_WAITING) begin
            phase_nxt = PH_ACTIVE;
          end
          ok = 1'b1;
        end
      end
      CMD_DEQUEUE: begin
        if (runnable_cur) begin
          queued_nxt = q_sub;
          deq_nxt    = deq_inc;
          if (phase_r == PH_ACTIVE) begin
            if (deq_inc == exp_r) begin
              act0 = ACT_FINALIZE;
            end else if (ovf_r && q_sub == '0) begin
              act0      = ACT_RUN;
              phase_nxt = PH_WAITING;
              ovf_nxt   = 1'b0;
            end
          end
          ok = 1'b1;
        end
      end
      CMD_COMPLETE: begin
        if (done_action == ACT_FINALIZE) begin
          phase_nxt = PH_COMPLETE;
          ok        = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Result as seen after the update
  always_comb begin
    result.accepted      = ok;
    result.first_action  = act0;
    result.second_action = act1;
    result.task_state    = phase_nxt;
    result.runnable      = (phase_nxt == PH_ACTIVE) || (phase_nxt == PH_WAITING) ||
                           (phase_nxt == PH_PAUSED);
    result.busy_res      = (phase_nxt == PH_ACTIVE) || (phase_nxt == PH_WAITING);
    result.healthy       = ~err_nxt;
    result.overflowed    = ovf_nxt;
  end

  // Hold state; advance on each request that leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_QUEUED;
      queued_r     <= '0;
      enq_r        <= '0;
      deq_r        <= '0;
      exp_r        <= '0;
      err_r        <= 1'b0;
      ovf_r        <= 1'b0;
      high_water_r <= HIGH_WATER_RESET;
    end else begin
      if (cfg_we) high_water_r <= cfg_wdata;
      if (fire) begin
        phase_r  <= phase_nxt;
        queued_r <= queued_nxt;
        enq_r    <= enq_nxt;
        deq_r    <= deq_nxt;
        exp_r    <= exp_nxt;
        err_r    <= err_nxt;
        ovf_r    <= ovf_nxt;
      end
    end
  end

endmodule

/* rtl/task_lifecycle_flow_control.sv */
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; the input register advances whenever the
// result register is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): lifecycle state, counters and flags clear,
// high-water mark returns to 50 MiB, both stages empty.
// Top level of the task lifecycle controller: input stage and result register.
module task_lifecycle_flow_control
  import tlfc_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_cmd,
  input  logic [31:0] in_buffer_total,
  input  logic [31:0] in_byte_amount,
  input  logic [2:0]  in_done_action,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_accepted,
  output logic [2:0]  out_first_action,
  output logic [2:0]  out_second_action,
  output logic [2:0]  out_task_state,
  output logic        out_runnable,
  output logic        out_busy_res,
  output logic        out_healthy,
  output logic        out_overflowed
);

`include "task_lifecycle_flow_control_macros.svh"

  logic        s1_valid_r;
  logic [3:0]  s1_cmd_r;
  logic [31:0] s1_total_r;
  logic [31:0] s1_bytes_r;
  logic [2:0]  s1_done_r;
  logic        out_valid_r;
  result_t     res_r;
  result_t     res_nxt;
  logic        adv;
  logic        fire;

  // Advance when the result register can take a new value
  assign adv      = !out_valid_r || out_ready;
  assign fire     = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  tlfc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .fire         (fire),
    .cmd          (s1_cmd_r),
    .buffer_total (s1_total_r),
    .byte_amount  (s1_bytes_r),
    .done_action  (s1_done_r),
    .result       (res_nxt)
  );

  // Hold the input request and the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) s1_valid_r <= in_valid;
      if (adv) out_valid_r <= s1_valid_r;
    end
    if (in_ready && in_valid) begin
      s1_cmd_r   <= in_cmd;
      s1_total_r <= in_buffer_total;
      s1_bytes_r <= in_byte_amount;
      s1_done_r  <= in_done_action;
    end
    if (fire) res_r <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = res_r.accepted;
  assign out_first_action  = res_r.first_action;
  assign out_second_action = res_r.second_action;
  assign out_task_state    = res_r.task_state;
  assign out_runnable      = res_r.runnable;
  assign out_busy_res      = res_r.busy_res;
  assign out_healthy       = res_r.healthy;
  assign out_overflowed    = res_r.overflowed;

  `TLFC_ASSERT_IMPL(a_refused_no_action, out_valid_r && !res_r.accepted, res_r.first_action == ACT_NONE && res_r.second_action == ACT_NONE, "refused request emitted an action")
  `TLFC_ASSERT_IMPL(a_action_order, out_valid_r && res_r.second_action != ACT_NONE, res_r.first_action != ACT_NONE, "second action without a first")
  `TLFC_ASSERT_IMPL(a_busy_runnable, out_valid_r && res_r.busy_res, res_r.runnable, "busy task not runnable")
  `TLFC_ASSERT_NEXT(a_result_kept, out_valid_r && !out_ready, out_valid_r && $stable(res_r), "stalled result changed")

endmodule

/* dv/task_lifecycle_flow_control_tb.sv */
// Self-checking testbench for the task lifecycle flow controller.
module task_lifecycle_flow_control_tb;
  import tlfc_pkg::*;

  // Lifecycle phases as reported on out_task_state
  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_WAITING  = 3'd1,
    ST_ACTIVE   = 3'd2,
    ST_PAUSED   = 3'd3,
    ST_COMPLETE = 3'd4,
    ST_KILLED   = 3'd5
  } lc_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_cmd = '0;
  logic [31:0] in_buffer_total = '0;
  logic [31:0] in_byte_amount = '0;
  logic [2:0]  in_done_action = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_accepted;
  logic [2:0]  out_first_action;
  logic [2:0]  out_second_action;
  logic [2:0]  out_task_state;
  logic        out_runnable;
  logic        out_busy_res;
  logic        out_healthy;
  logic        out_overflowed;

  // Lifecycle tracker: mirrors the controller state after each accepted request
  logic [31:0] high_water = HIGH_WATER_RESET;
  lc_state_t   ctl_state = ST_QUEUED;
  logic [31:0] buffered_bytes = '0;
  logic [31:0] enq_count = '0;
  logic [31:0] deq_count = '0;
  logic [31:0] buffer_goal = '0;
  logic        fault_seen = 1'b0;
  logic        overflow_seen = 1'b0;

  result_t     lifecycle_results[$];
  int          error_count = 0;
  int          burst_left = 0;
  int          rx_mode = 0;
  int          rx_mode_left = 0;
  int          rx_tick = 0;

  task_lifecycle_flow_control uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_buffer_total   (in_buffer_total),
    .in_byte_amount    (in_byte_amount),
    .in_done_action    (in_done_action),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_first_action  (out_first_action),
    .out_second_action (out_second_action),
    .out_task_state    (out_task_state),
    .out_runnable      (out_runnable),
    .out_busy_res      (out_busy_res),
    .out_healthy       (out_healthy),
    .out_overflowed    (out_overflowed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic runnable_now();
    return ctl_state == ST_ACTIVE || ctl_state == ST_WAITING || ctl_state == ST_PAUSED;
  endfunction

  function automatic logic busy_now();
    return ctl_state == ST_ACTIVE || ctl_state == ST_WAITING;
  endfunction

  // Apply one request to the tracker and queue the status it should produce
  task automatic step_lifecycle(input logic [3:0] cmd_code, input logic [31:0] total,
                                input logic [31:0] amount, input logic [2:0] done_code);
    result_t r;
    action_t acts[$];
    logic    ok;
    ok = 1'b0;
    case (cmd_code)
      CMD_RESET: begin
        ctl_state = ST_QUEUED;
        buffered_bytes = '0;
        enq_count = '0;
        deq_count = '0;
        buffer_goal = '0;
        fault_seen = 1'b0;
        overflow_seen = 1'b0;
        ok = 1'b1;
      end
      CMD_START: if (ctl_state == ST_QUEUED) begin
        acts.push_back(ACT_PREPARE);
        acts.push_back(ACT_RUN);
        ctl_state = ST_WAITING;
        ok = 1'b1;
      end
      CMD_PAUSE: if (ctl_state == ST_QUEUED || busy_now()) begin
        if (ctl_state == ST_ACTIVE) acts.push_back(ACT_STOP);
        ctl_state = ST_PAUSED;
        ok = 1'b1;
      end
      CMD_RESUME: if (ctl_state == ST_PAUSED) begin
        if (buffer_goal != 0) begin
          acts.push_back(ACT_RUN);
          ctl_state = ST_WAITING;
        end else begin
          ctl_state = ST_QUEUED;
        end
        ok = 1'b1;
      end
      CMD_FLUSH: if (runnable_now()) begin
        acts.push_back(ACT_FLUSH);
        ok = 1'b1;
      end
      CMD_KILL: if (ctl_state != ST_KILLED) begin
        if (busy_now()) begin
          acts.push_back(ACT_STOP);
          acts.push_back(ACT_CANCEL);
        end else if (ctl_state == ST_PAUSED) begin
          acts.push_back(ACT_CANCEL);
        end
        ctl_state = ST_KILLED;
        ok = 1'b1;
      end
      CMD_FAULT: if (runnable_now()) begin
        if (busy_now()) acts.push_back(ACT_STOP);
        acts.push_back(ACT_CANCEL);
        ctl_state = ST_COMPLETE;
        fault_seen = 1'b1;
        ok = 1'b1;
      end
      CMD_DISRUPT: if (ctl_state == ST_ACTIVE) begin
        ctl_state = ST_WAITING;
        ok = 1'b1;
      end
      CMD_PREPARE: if (ctl_state == ST_WAITING && buffer_goal == 0) begin
        buffer_goal = total;
        ok = 1'b1;
      end
      CMD_ENQUEUE: if (runnable_now()) begin
        // saturate the byte count instead of wrapping
        if (amount > ~buffered_bytes) buffered_bytes = '1;
        else buffered_bytes = buffered_bytes + amount;
        enq_count = enq_count + 1;
        if (ctl_state == ST_ACTIVE) begin
          if (enq_count == buffer_goal) begin
            acts.push_back(ACT_STOP);
          end else if (buffered_bytes >= high_water) begin
            acts.push_back(ACT_STOP);
            ctl_state = ST_WAITING;
            overflow_seen = 1'b1;
          end
        end else if (ctl_state == ST_WAITING) begin
          ctl_state = ST_ACTIVE;
        end
        ok = 1'b1;
      end
      CMD_DEQUEUE: if (runnable_now()) begin
        // floor the byte count at zero
        if (amount > buffered_bytes) buffered_bytes = '0;
        else buffered_bytes = buffered_bytes - amount;
        deq_count = deq_count + 1;
        if (ctl_state == ST_ACTIVE) begin
          if (deq_count == buffer_goal) begin
            acts.push_back(ACT_FINALIZE);
          end else if (overflow_seen && buffered_bytes == 0) begin
            acts.push_back(ACT_RUN);
            ctl_state = ST_WAITING;
            overflow_seen = 1'b0;
          end
        end
        ok = 1'b1;
      end
      CMD_COMPLETE: if (done_code == ACT_FINALIZE) begin
        ctl_state = ST_COMPLETE;
        ok = 1'b1;
      end
      default: ;
    endcase
    r.accepted = ok;
    r.first_action = (acts.size() > 0) ? acts[0] : ACT_NONE;
    r.second_action = (acts.size() > 1) ? acts[1] : ACT_NONE;
    r.task_state = ctl_state;
    r.runnable = runnable_now();
    r.busy_res = busy_now();
    r.healthy = !fault_seen;
    r.overflowed = overflow_seen;
    lifecycle_results.push_back(r);
  endtask

  // Track register writes and accepted requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) high_water = cfg_wdata;
      if (in_valid && in_ready)
        step_lifecycle(in_cmd, in_buffer_total, in_byte_amount, in_done_action);
    end
  end

  task automatic check_field(input string label, input logic [2:0] want, input logic [2:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, label, want, got);
      error_count++;
    end
  endtask

  // Compare each delivered status with the oldest pending one
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (lifecycle_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got state %0d", $time,
                 out_task_state);
        error_count++;
      end else begin
        want = lifecycle_results.pop_front();
        check_field("accepted", want.accepted, out_accepted);
        check_field("first_action", want.first_action, out_first_action);
        check_field("second_action", want.second_action, out_second_action);
        check_field("task_state", want.task_state, out_task_state);
        check_field("runnable", want.runnable, out_runnable);
        check_field("busy_res", want.busy_res, out_busy_res);
        check_field("healthy", want.healthy, out_healthy);
        check_field("overflowed", want.overflowed, out_overflowed);
      end
    end
  end

  // Stall the result side: always ready, light stalls, heavy stalls or a fixed rhythm
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 200);
    end else begin
      rx_mode_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_tick % 4 != 0);
    endcase
  end

  // Present one request, hold it until taken, then maybe open a gap
  task automatic send_request(input logic [3:0] c, input logic [31:0] tot,
                              input logic [31:0] amt, input logic [2:0] dn);
    int gap;
    in_valid = 1'b1;
    in_cmd = c;
    in_buffer_total = tot;
    in_byte_amount = amt;
    in_done_action = dn;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 4) : $urandom_range(10, 60);
    end
  endtask

  // Drop valid and wait until every pending status has come back
  task automatic settle_pipeline();
    in_valid = 1'b0;
    while (lifecycle_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_high_water(input logic [31:0] mark);
    cfg_wdata = mark;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] pick_amount();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      3: return high_water;
      default: return $urandom_range(0, high_water / 3 + 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_total();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return $urandom;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  // An unknown code, complete with a wrong and then the finalize action code, kill twice, reset
  task automatic test_refusals_and_reset();
    send_request(4'hF, '1, '1, 3'h7);
    send_request(CMD_COMPLETE, '0, '0, 3'h7);
    send_request(CMD_COMPLETE, '0, '0, ACT_FINALIZE);
    send_request(CMD_KILL, '0, '0, ACT_NONE);
    send_request(CMD_KILL, '0, '0, ACT_NONE);
    send_request(CMD_RESET, '0, '0, ACT_NONE);
    settle_pipeline();
  endtask

  // Walk the main lifecycle: saturation, overflow stop, drain restart, pause, fault
  task automatic test_lifecycle_walk();
    send_request(CMD_START, '0, '0, ACT_NONE);
    send_request(CMD_PREPARE, '1, '0, ACT_NONE);
    send_request(CMD_PREPARE, 32'd1, '0, ACT_NONE);
    send_request(CMD_ENQUEUE, '0, '1, ACT_NONE);
    send_request(CMD_ENQUEUE, '0, '1, ACT_NONE);
    send_request(CMD_ENQUEUE, '0, '0, ACT_NONE);
    send_request(CMD_DEQUEUE, '0, '1, ACT_NONE);
    send_request(CMD_FLUSH, '0, '0, ACT_NONE);
    send_request(CMD_DISRUPT, '0, '0, ACT_NONE);
    send_request(CMD_ENQUEUE, '0, '0, ACT_NONE);
    send_request(CMD_DISRUPT, '0, '0, ACT_NONE);
    send_request(CMD_PAUSE, '0, '0, ACT_NONE);
    send_request(CMD_RESUME, '0, '0, ACT_NONE);
    send_request(CMD_FAULT, '0, '0, ACT_NONE);
    settle_pipeline();
  endtask

  // Resume without a goal, then finalize on the last dequeue with bytes still held
  task automatic test_finalize_with_bytes_left();
    send_request(CMD_RESET, '0, '0, ACT_NONE);
    send_request(CMD_PAUSE, '0, '0, ACT_NONE);
    send_request(CMD_RESUME, '0, '0, ACT_NONE);
    send_request(CMD_START, '0, '0, ACT_NONE);
    send_request(CMD_PREPARE, 32'd2, '0, ACT_NONE);
    send_request(CMD_ENQUEUE, '0, 32'd5, ACT_NONE);
    send_request(CMD_DEQUEUE, '0, '0, ACT_NONE);
    send_request(CMD_DEQUEUE, '0, '0, ACT_NONE);
    send_request(CMD_KILL, '0, '0, ACT_NONE);
    settle_pipeline();
  endtask

  // Mostly state-aware sessions with random content, plus some raw noise
  task automatic run_random_sessions(input int target);
    int          taken;
    int          pick;
    logic [3:0]  c;
    logic [31:0] tot;
    logic [31:0] amt;
    logic [2:0]  dn;
    taken = 0;
    while (taken < target) begin
      pick = $urandom_range(0, 99);
      tot = pick_total();
      amt = pick_amount();
      dn = ($urandom_range(0, 4) == 0) ? 3'($urandom) : ACT_FINALIZE;
      if ($urandom_range(0, 99) < 8) begin
        c = 4'($urandom);
      end else begin
        case (ctl_state)
          ST_QUEUED:
            if (pick < 75) c = CMD_START;
            else if (pick < 85) c = CMD_PAUSE;
            else if (pick < 92) c = CMD_COMPLETE;
            else c = CMD_KILL;
          ST_WAITING:
            if (buffer_goal == 0 && pick < 35) c = CMD_PREPARE;
            else if (pick < 75) c = CMD_ENQUEUE;
            else if (pick < 82) c = CMD_DEQUEUE;
            else if (pick < 87) c = CMD_PAUSE;
            else if (pick < 91) c = CMD_FLUSH;
            else if (pick < 94) c = CMD_DISRUPT;
            else if (pick < 97) c = CMD_KILL;
            else c = CMD_FAULT;
          ST_ACTIVE:
            if (pick < 45) c = CMD_ENQUEUE;
            else if (pick < 82) c = CMD_DEQUEUE;
            else if (pick < 86) c = CMD_DISRUPT;
            else if (pick < 89) c = CMD_PAUSE;
            else if (pick < 92) c = CMD_FLUSH;
            else if (pick < 94) c = CMD_PREPARE;
            else if (pick < 96) c = CMD_KILL;
            else if (pick < 98) c = CMD_FAULT;
            else c = CMD_COMPLETE;
          ST_PAUSED:
            if (pick < 55) c = CMD_RESUME;
            else if (pick < 65) c = CMD_ENQUEUE;
            else if (pick < 75) c = CMD_DEQUEUE;
            else if (pick < 82) c = CMD_FLUSH;
            else if (pick < 88) c = CMD_KILL;
            else if (pick < 94) c = CMD_FAULT;
            else c = CMD_START;
          default:
            if (pick < 70) c = CMD_RESET;
            else if (pick < 80) c = CMD_KILL;
            else if (pick < 88) c = CMD_COMPLETE;
            else c = CMD_START;
        endcase
        // drain exactly or past zero often enough to restart after overflow
        if (c == CMD_DEQUEUE) begin
          case ($urandom_range(0, 9))
            0, 1, 2: amt = buffered_bytes;
            3, 4: amt = buffered_bytes + $urandom_range(1, 100);
            default: ;
          endcase
        end
      end
      send_request(c, tot, amt, dn);
      taken++;
    end
    settle_pipeline();
  endtask

  // Random sessions at the reset mark, then at each programmed high-water mark
  task automatic test_high_water_sweep();
    logic [31:0] marks[4];
    marks[0] = 32'd1;
    marks[1] = 32'hFFFF_FFFF;
    marks[2] = $urandom_range(2, 100000);
    marks[3] = 32'd4096;
    run_random_sessions(205);
    foreach (marks[i]) begin
      program_high_water(marks[i]);
      run_random_sessions(205);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_refusals_and_reset();
    test_lifecycle_walk();
    test_finalize_with_bytes_left();
    test_high_water_sweep();
    repeat (10) @(negedge clk);
    if (error_count == 0 && lifecycle_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
